// ===== src/qbf_pkg.sv =====
// Shared constants, command word type and codes for the quadratic Bezier flattener.
package qbf_pkg;

    localparam int COORD_BITS   = 24;
    localparam int FRAC_BITS    = 8;
    localparam int MAX_SAMPLES  = 64;
    localparam int CFG_BITS     = 7;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd16;
    localparam int QUEUE_DEPTH  = 2;
    localparam int W_BITS       = 13;   // Bernstein weight, up to 63*63

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // command kinds
    localparam logic [1:0] K_ONE = 2'd0;    // emit p0, last
    localparam logic [1:0] K_TWO = 2'd1;    // emit p0 then p2
    localparam logic [1:0] K_SEG = 2'd2;    // flatten segment p0,p1,p2

    typedef struct packed {
        logic [1:0] kind;
        coord_t     p0x;
        coord_t     p0y;
        coord_t     p1x;
        coord_t     p1y;
        coord_t     p2x;
        coord_t     p2y;
    } cmd_t;

endpackage

// ===== src/qbf_front.sv =====
// Front end: takes control points, tracks list state and issues segment commands.
module qbf_front
    import qbf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  coord_t ctrl_x,
    input  coord_t ctrl_y,
    input  logic   list_end,
    input  logic   q_full,
    output logic   q_push,
    output cmd_t   q_cmd
);

    localparam logic [1:0] PS_NONE = 2'd0;
    localparam logic [1:0] PS_ONE  = 2'd1;
    localparam logic [1:0] PS_MANY = 2'd2;

    logic [1:0] ps_reg, ps_next;
    coord_t     start_x_reg, start_x_next, start_y_reg, start_y_next;
    coord_t     held_x_reg, held_x_next, held_y_reg, held_y_next;
    logic       accept;
    logic signed [COORD_BITS:0] sum_x, sum_y;
    coord_t     mid_x, mid_y;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    // midpoint, rounded half up
    assign sum_x = $signed({held_x_reg[COORD_BITS-1], held_x_reg})
                 + $signed({ctrl_x[COORD_BITS-1], ctrl_x}) + (COORD_BITS+1)'(1);
    assign sum_y = $signed({held_y_reg[COORD_BITS-1], held_y_reg})
                 + $signed({ctrl_y[COORD_BITS-1], ctrl_y}) + (COORD_BITS+1)'(1);
    assign mid_x = sum_x[COORD_BITS:1];
    assign mid_y = sum_y[COORD_BITS:1];

    always_comb
    begin
        ps_next      = ps_reg;
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        held_x_next  = held_x_reg;
        held_y_next  = held_y_reg;
        q_push       = 1'b0;
        q_cmd.kind   = K_ONE;
        q_cmd.p0x    = start_x_reg;
        q_cmd.p0y    = start_y_reg;
        q_cmd.p1x    = held_x_reg;
        q_cmd.p1y    = held_y_reg;
        q_cmd.p2x    = ctrl_x;
        q_cmd.p2y    = ctrl_y;
        if (accept)
        begin
            case (ps_reg)
                PS_NONE:
                begin
                    if (!list_end)
                    begin
                        start_x_next = ctrl_x;
                        start_y_next = ctrl_y;
                        ps_next      = PS_ONE;
                    end
                end
                PS_ONE:
                begin
                    q_push = 1'b1;
                    if (list_end)
                    begin
                        q_cmd.kind = K_TWO;
                        ps_next    = PS_NONE;
                    end
                    else
                    begin
                        q_cmd.kind  = K_ONE;
                        held_x_next = ctrl_x;
                        held_y_next = ctrl_y;
                        ps_next     = PS_MANY;
                    end
                end
                default:
                begin
                    q_push     = 1'b1;
                    q_cmd.kind = K_SEG;
                    if (list_end)
                    begin
                        ps_next = PS_NONE;
                    end
                    else
                    begin
                        q_cmd.p2x    = mid_x;
                        q_cmd.p2y    = mid_y;
                        start_x_next = mid_x;
                        start_y_next = mid_y;
                        held_x_next  = ctrl_x;
                        held_y_next  = ctrl_y;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg      <= PS_NONE;
            start_x_reg <= '0;
            start_y_reg <= '0;
            held_x_reg  <= '0;
            held_y_reg  <= '0;
        end
        else
        begin
            ps_reg      <= ps_next;
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            held_x_reg  <= held_x_next;
            held_y_reg  <= held_y_next;
        end
    end

endmodule

// ===== src/qbf_queue.sv =====
// Short command queue between front and back ends.
module qbf_queue
    import qbf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/qbf_back.sv =====
// Back end: evaluates and thins segment samples, drives the output word register.
module qbf_back
    import qbf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CFG_BITS-1:0] samples_per_segment,
    input  logic                q_empty,
    input  cmd_t                q_cmd,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output coord_t              curve_x,
    output coord_t              curve_y,
    output logic                run_end
);

    localparam int PW    = COORD_BITS + W_BITS + 1;   // weighted product
    localparam int SW    = COORD_BITS + W_BITS + 3;   // sum of products
    localparam int RW    = W_BITS + 1;                // divider remainder
    localparam int CNT_W = $clog2(COORD_BITS);
    localparam int DW    = 34;                        // coordinate difference
    localparam int QW    = 63;                        // squared distance

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EMIT0 = 4'd1;
    localparam logic [3:0] S_EMIT2 = 4'd2;
    localparam logic [3:0] S_WGT   = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_SUM   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_DIST  = 4'd7;
    localparam logic [3:0] S_SQ    = 4'd8;
    localparam logic [3:0] S_CMP   = 4'd9;
    localparam logic [3:0] S_EMITS = 4'd10;

    logic [3:0]          state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [CFG_BITS-1:0] n_reg, n_next, i_reg, i_next, a_val;
    logic [W_BITS-1:0]   den_reg, den_next;
    logic [W_BITS-1:0]   w0_reg, w0_next, w1_reg, w1_next, w2_reg, w2_next;
    logic signed [PW-1:0] px0_reg, px1_reg, px2_reg, py0_reg, py1_reg, py2_reg;
    logic signed [SW-1:0] ux_reg, uy_reg;
    logic [RW-1:0]       remx_reg, remx_next, remy_reg, remy_next;
    coord_t              qx_reg, qx_next, qy_reg, qy_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    coord_t              sx_reg, sx_next, sy_reg, sy_next;
    coord_t              lx_reg, lx_next, ly_reg, ly_next;
    logic                kept_reg, kept_next, chk_reg, chk_next;
    logic                big_reg, big_next;
    logic [30:0]         dxa_reg, dxa_next, dya_reg, dya_next;
    logic [QW-1:0]       sq_reg;
    logic                out_valid_reg, out_valid_next, run_end_reg, run_end_next;
    coord_t              cx_reg, cx_next, cy_reg, cy_next;
    logic                out_free, far;
    coord_t              ax, ay, bx, by;
    logic signed [DW-1:0] dx, dy;
    logic [DW-1:0]       adx, ady;
    logic [RW:0]         tx, ty;

    assign out_valid = out_valid_reg;
    assign curve_x   = cx_reg;
    assign curve_y   = cy_reg;
    assign run_end   = run_end_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign a_val     = n_reg - i_reg;
    assign far       = big_reg || (sq_reg > (QW'(1) << (2 * FRAC_BITS)));

    // distance operands: sample against last kept, or segment end against start
    assign ax  = chk_reg ? cmd_reg.p0x : lx_reg;
    assign ay  = chk_reg ? cmd_reg.p0y : ly_reg;
    assign bx  = chk_reg ? cmd_reg.p2x : (qx_reg ^ {1'b1, {(COORD_BITS-1){1'b0}}});
    assign by  = chk_reg ? cmd_reg.p2y : (qy_reg ^ {1'b1, {(COORD_BITS-1){1'b0}}});
    assign dx  = DW'(bx) - DW'(ax);
    assign dy  = DW'(by) - DW'(ay);
    assign adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
    assign ady = dy[DW-1] ? DW'(-dy) : DW'(dy);

    // one restoring step per cycle
    assign tx = {remx_reg, ux_reg[COORD_BITS-1]};
    assign ty = {remy_reg, uy_reg[COORD_BITS-1]};

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        n_next         = n_reg;
        den_next       = den_reg;
        i_next         = i_reg;
        w0_next        = w0_reg;
        w1_next        = w1_reg;
        w2_next        = w2_reg;
        remx_next      = remx_reg;
        remy_next      = remy_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        cnt_next       = cnt_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        lx_next        = lx_reg;
        ly_next        = ly_reg;
        kept_next      = kept_reg;
        chk_next       = chk_reg;
        big_next       = big_reg;
        dxa_next       = dxa_reg;
        dya_next       = dya_reg;
        q_pop          = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        run_end_next   = run_end_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    cmd_next  = q_cmd;
                    kept_next = 1'b0;
                    chk_next  = 1'b0;
                    i_next    = CFG_BITS'(1);
                    lx_next   = q_cmd.p0x;
                    ly_next   = q_cmd.p0y;
                    if (samples_per_segment == '0)
                    begin
                        n_next = CFG_BITS'(1);
                    end
                    else if (samples_per_segment > CFG_BITS'(MAX_SAMPLES))
                    begin
                        n_next = CFG_BITS'(MAX_SAMPLES);
                    end
                    else
                    begin
                        n_next = samples_per_segment;
                    end
                    den_next   = W_BITS'(n_next) * W_BITS'(n_next);
                    state_next = (q_cmd.kind == K_SEG) ? S_WGT : S_EMIT0;
                end
            end
            S_EMIT0:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    cx_next        = cmd_reg.p0x;
                    cy_next        = cmd_reg.p0y;
                    run_end_next   = (cmd_reg.kind == K_ONE);
                    state_next     = (cmd_reg.kind == K_ONE) ? S_IDLE : S_EMIT2;
                end
            end
            S_EMIT2:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    cx_next        = cmd_reg.p2x;
                    cy_next        = cmd_reg.p2y;
                    run_end_next   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_WGT:
            begin
                if ((i_reg + CFG_BITS'(1)) >= n_reg)
                begin
                    chk_next   = 1'b1;
                    state_next = S_DIST;
                end
                else
                begin
                    w0_next    = W_BITS'(a_val) * W_BITS'(a_val);
                    w1_next    = (W_BITS'(i_reg) * W_BITS'(a_val)) << 1;
                    w2_next    = W_BITS'(i_reg) * W_BITS'(i_reg);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (tx >= (RW+1)'(den_reg))
                begin
                    remx_next = RW'(tx - (RW+1)'(den_reg));
                    qx_next   = {qx_reg[COORD_BITS-2:0], 1'b1};
                end
                else
                begin
                    remx_next = RW'(tx);
                    qx_next   = {qx_reg[COORD_BITS-2:0], 1'b0};
                end
                if (ty >= (RW+1)'(den_reg))
                begin
                    remy_next = RW'(ty - (RW+1)'(den_reg));
                    qy_next   = {qy_reg[COORD_BITS-2:0], 1'b1};
                end
                else
                begin
                    remy_next = RW'(ty);
                    qy_next   = {qy_reg[COORD_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(COORD_BITS-1))
                begin
                    state_next = S_DIST;
                end
            end
            S_DIST:
            begin
                sx_next    = bx;
                sy_next    = by;
                big_next   = (|adx[DW-1:31]) || (|ady[DW-1:31]);
                dxa_next   = adx[30:0];
                dya_next   = ady[30:0];
                state_next = S_SQ;
            end
            S_SQ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (chk_reg)
                begin
                    state_next = (kept_reg || far) ? S_EMIT2 : S_IDLE;
                end
                else if (far)
                begin
                    state_next = S_EMITS;
                end
                else
                begin
                    i_next     = i_reg + CFG_BITS'(1);
                    state_next = S_WGT;
                end
            end
            S_EMITS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    cx_next        = sx_reg;
                    cy_next        = sy_reg;
                    run_end_next   = 1'b0;
                    lx_next        = sx_reg;
                    ly_next        = sy_reg;
                    kept_next      = 1'b1;
                    i_next         = i_reg + CFG_BITS'(1);
                    state_next     = S_WGT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        n_reg    <= n_next;
        den_reg  <= den_next;
        i_reg    <= i_next;
        w0_reg   <= w0_next;
        w1_reg   <= w1_next;
        w2_reg   <= w2_next;
        px0_reg  <= PW'($signed({1'b0, w0_reg})) * PW'(cmd_reg.p0x);
        px1_reg  <= PW'($signed({1'b0, w1_reg})) * PW'(cmd_reg.p1x);
        px2_reg  <= PW'($signed({1'b0, w2_reg})) * PW'(cmd_reg.p2x);
        py0_reg  <= PW'($signed({1'b0, w0_reg})) * PW'(cmd_reg.p0y);
        py1_reg  <= PW'($signed({1'b0, w1_reg})) * PW'(cmd_reg.p1y);
        py2_reg  <= PW'($signed({1'b0, w2_reg})) * PW'(cmd_reg.p2y);
        if (state_reg == S_SUM)
        begin
            // bias by half the divisor for rounding and by 2^(CB-1) divisors
            // so the dividend is never negative
            ux_reg <= SW'(px0_reg) + SW'(px1_reg) + SW'(px2_reg)
                    + SW'(den_reg >> 1) + (SW'(den_reg) << (COORD_BITS - 1));
            uy_reg <= SW'(py0_reg) + SW'(py1_reg) + SW'(py2_reg)
                    + SW'(den_reg >> 1) + (SW'(den_reg) << (COORD_BITS - 1));
        end
        else if (state_reg == S_DIV)
        begin
            ux_reg <= ux_reg << 1;
            uy_reg <= uy_reg << 1;
        end
        if (state_reg == S_SUM)
        begin
            remx_reg <= RW'((SW'(px0_reg) + SW'(px1_reg) + SW'(px2_reg)
                    + SW'(den_reg >> 1) + (SW'(den_reg) << (COORD_BITS - 1))) >> COORD_BITS);
            remy_reg <= RW'((SW'(py0_reg) + SW'(py1_reg) + SW'(py2_reg)
                    + SW'(den_reg >> 1) + (SW'(den_reg) << (COORD_BITS - 1))) >> COORD_BITS);
        end
        else
        begin
            remx_reg <= remx_next;
            remy_reg <= remy_next;
        end
        qx_reg   <= qx_next;
        qy_reg   <= qy_next;
        cnt_reg  <= cnt_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        lx_reg   <= lx_next;
        ly_reg   <= ly_next;
        kept_reg <= kept_next;
        chk_reg  <= chk_next;
        big_reg  <= big_next;
        dxa_reg  <= dxa_next;
        dya_reg  <= dya_next;
        sq_reg   <= QW'(dxa_reg) * QW'(dxa_reg) + QW'(dya_reg) * QW'(dya_reg);
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        run_end_reg <= run_end_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/quadratic_bezier_flattener.sv =====
// Top level of the quadratic Bezier flattener: config register, front, queue and back.
//
// Control points stream in, one word each, list_end on the last point of a list.
// Three or more points become a chain of quadratic segments (midpoints of
// neighbouring points as joins); each segment is sampled at t = i/N, i = 1..N-2,
// and a sample is sent only when it lies more than one unit from the last
// sample kept (initially the segment start); the segment end is sent when any
// sample was kept or when it lies more than one unit from the segment start.
// Two-point lists pass through; one-point lists give nothing. The front end keeps
// list state and queues at most one command per point (none for a list's first
// point) into a two-entry queue, so input keeps flowing while the back end works
// until the queue is full. Each sample is rounded by a bit-serial divider (one
// quotient bit per cycle, both axes in parallel). The user must write
// samples_per_segment (reset 16) via the cfg port only while the block is idle;
// the block itself does not enforce this. 0 acts as 1, above 64 as 64.
module quadratic_bezier_flattener
    import qbf_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  coord_t              ctrl_x,
    input  coord_t              ctrl_y,
    input  logic                list_end,
    output logic                out_valid,
    input  logic                out_stall,
    output coord_t              curve_x,
    output coord_t              curve_y,
    output logic                run_end,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_BITS-1:0] cfg_data
);

    logic [CFG_BITS-1:0] samples_reg, samples_next;
    logic                q_push, q_pop, q_full, q_empty;
    cmd_t                push_cmd, pop_cmd;

    // config register always takes the word
    assign cfg_ready    = 1'b1;
    assign samples_next = (cfg_valid && cfg_ready) ? cfg_data : samples_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_reg <= CFG_RESET;
        end
        else
        begin
            samples_reg <= samples_next;
        end
    end

    qbf_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .ctrl_x   (ctrl_x),
        .ctrl_y   (ctrl_y),
        .list_end (list_end),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    qbf_queue #(.DEPTH(QUEUE_DEPTH_P)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    qbf_back u_back
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .samples_per_segment (samples_reg),
        .q_empty             (q_empty),
        .q_cmd               (pop_cmd),
        .q_pop               (q_pop),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .curve_x             (curve_x),
        .curve_y             (curve_y),
        .run_end             (run_end)
    );

endmodule

// ===== src/qbf_checker.sv =====
// Port-level checks for the flattener, bound to the top level.
module qbf_checker
    import qbf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input logic cfg_ready,
    input logic in_valid,
    input logic in_stall
);

    // a stalled word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

    // nothing is sent in the first cycle out of reset
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !out_valid)
        else $error("output word right after reset");

    // queue empty out of reset, so input is taken at once
    a_reset_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !in_stall)
        else $error("input stalled right after reset");

endmodule

bind quadratic_bezier_flattener qbf_checker u_qbf_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_ready (cfg_ready),
    .in_valid  (in_valid),
    .in_stall  (in_stall)
);

// ===== tb/flatten_checker.sv =====
// Checker for the flattener: watches both channels and the cfg port, predicts curve words.
`timescale 1ns / 100ps
module flatten_checker
    import qbf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  coord_t              ctrl_x,
    input  coord_t              ctrl_y,
    input  logic                list_end,
    input  logic                out_valid,
    input  logic                out_stall,
    input  coord_t              curve_x,
    input  coord_t              curve_y,
    input  logic                run_end,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [CFG_BITS-1:0] cfg_data,
    output int                  fail_count,
    output int                  pending,
    output int                  words_checked
);

    typedef struct {
        coord_t x;
        coord_t y;
        logic   last;
    } curve_word_t;

    curve_word_t expected_curve_q[$];

    longint           seg_x, seg_y, held_x, held_y;
    int               points_in_list;
    logic [CFG_BITS-1:0] steps_reg;
    int               step_words;

    assign pending = expected_curve_q.size();

    function automatic longint floor_div(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit beyond_unit(longint ax, longint ay, longint bx, longint by);
        longint dx, dy;
        dx = mag(bx - ax);
        dy = mag(by - ay);
        if (dx >= (64'sd1 << 31) || dy >= (64'sd1 << 31))
            return 1'b1;
        return (dx * dx + dy * dy) > (64'sd1 << (2 * FRAC_BITS));
    endfunction

    function automatic longint bezier_at(longint c0, longint c1, longint c2,
                                         longint i, longint n);
        longint a, den, num;
        a   = n - i;
        den = n * n;
        num = a * a * c0 + 2 * i * a * c1 + i * i * c2;
        return floor_div(num + den / 2, den);
    endfunction

    task automatic emit(longint x, longint y);
        curve_word_t w;
        w.x    = coord_t'(x);
        w.y    = coord_t'(y);
        w.last = 1'b0;
        expected_curve_q.insert(expected_curve_q.size(), w);
        step_words++;
    endtask

    task automatic flatten_segment(longint ex, longint ey);
        longint n, lx, ly, sx, sy;
        bit     kept;
        n    = steps_reg;
        lx   = seg_x;
        ly   = seg_y;
        kept = 1'b0;
        if (n < 1)
            n = 1;
        if (n > MAX_SAMPLES)
            n = MAX_SAMPLES;
        for (longint i = 1; i < n - 1; i++)
        begin
            sx = bezier_at(seg_x, held_x, ex, i, n);
            sy = bezier_at(seg_y, held_y, ey, i, n);
            if (beyond_unit(lx, ly, sx, sy))
            begin
                emit(sx, sy);
                lx   = sx;
                ly   = sy;
                kept = 1'b1;
            end
        end
        if (kept || beyond_unit(seg_x, seg_y, ex, ey))
            emit(ex, ey);
    endtask

    task automatic predict_point(coord_t px, coord_t py, logic closes);
        longint x, y, mx, my;
        x = px;
        y = py;
        step_words = 0;
        if (points_in_list == 0)
        begin
            if (!closes)
            begin
                seg_x = x;
                seg_y = y;
                points_in_list = 1;
            end
        end
        else if (points_in_list == 1)
        begin
            emit(seg_x, seg_y);
            if (closes)
            begin
                emit(x, y);
                points_in_list = 0;
            end
            else
            begin
                held_x = x;
                held_y = y;
                points_in_list = 2;
            end
        end
        else if (closes)
        begin
            flatten_segment(x, y);
            points_in_list = 0;
        end
        else
        begin
            mx = floor_div(held_x + x + 1, 2);
            my = floor_div(held_y + y + 1, 2);
            flatten_segment(mx, my);
            seg_x  = mx;
            seg_y  = my;
            held_x = x;
            held_y = y;
        end
        if (step_words > 0)
            expected_curve_q[$].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        curve_word_t w;
        if (!rst_n)
        begin
            seg_x = 0; seg_y = 0; held_x = 0; held_y = 0;
            points_in_list = 0;
            steps_reg = CFG_RESET;
            expected_curve_q.delete();
            fail_count <= 0;
            words_checked <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                steps_reg = cfg_data;
            if (out_valid && !out_stall)
            begin
                words_checked <= words_checked + 1;
                if (expected_curve_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected word x=%0d y=%0d end=%0b",
                                 curve_x, curve_y, run_end);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    w = expected_curve_q.pop_front();
                    if (w.x !== curve_x || w.y !== curve_y || w.last !== run_end)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: exp x=%0d y=%0d end=%0b got x=%0d y=%0d end=%0b",
                                     w.x, w.y, w.last, curve_x, curve_y, run_end);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_point(ctrl_x, ctrl_y, list_end);
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the flattener testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps
module testbench;
    import qbf_pkg::*;

    localparam int  LIMIT  = 3000000;   // cycles
    localparam int  SETTLE = 6000;      // enough for three N=64 segments: one in the back end, two queued

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    coord_t              ctrl_x = '0;
    coord_t              ctrl_y = '0;
    logic                list_end = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    coord_t              curve_x;
    coord_t              curve_y;
    logic                run_end;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_BITS-1:0] cfg_data = '0;

    int  fail_count, pending, words_checked;
    int  cycles = 0;
    int  points_sent = 0;
    int  settings_used = 1;
    bit  calm = 1'b0;           // no idling on either side while set
    bit  word_taken = 1'b0;
    int  sink_wait = 0;

    always #6 clk = ~clk;

    quadratic_bezier_flattener u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .ctrl_x(ctrl_x), .ctrl_y(ctrl_y), .list_end(list_end),
        .out_valid(out_valid), .out_stall(out_stall),
        .curve_x(curve_x), .curve_y(curve_y), .run_end(run_end),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    flatten_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .ctrl_x(ctrl_x), .ctrl_y(ctrl_y), .list_end(list_end),
        .out_valid(out_valid), .out_stall(out_stall),
        .curve_x(curve_x), .curve_y(curve_y), .run_end(run_end),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .words_checked(words_checked)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // receiver: note each taken word at the edge ...
    always @(posedge clk)
        word_taken = out_valid && !out_stall;

    // ... and draw a fresh random stall for the next word
    always @(negedge clk)
    begin
        if (word_taken)
            sink_wait = calm ? 0 : $urandom_range(0, 9);
        if (sink_wait > 0)
        begin
            out_stall <= 1'b1;
            sink_wait = sink_wait - 1;
        end
        else
            out_stall <= 1'b0;
    end

    // one control point: optional gap, then hold the word until taken
    task automatic send_point(longint px, longint py, bit closes);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        ctrl_x   <= coord_t'(px);
        ctrl_y   <= coord_t'(py);
        list_end <= closes;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        points_sent++;
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    // wait for the block to drain, let queued no-result work finish, then write N
    task automatic set_steps(logic [CFG_BITS-1:0] n);
        drop_valid();
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic longint wide_coord();
        return longint'($urandom_range(0, 32'hFF_FFFF)) - 64'sd8388608;
    endfunction

    // a list of control points: mostly a local walk so the one-unit test bites
    task automatic random_list(int len);
        longint x, y;
        int     span, style;
        style = $urandom_range(0, 9);
        span  = (style < 4) ? 300 : (style < 8) ? 3000 : 0;
        x = wide_coord();
        y = wide_coord();
        for (int k = 0; k < len; k++)
        begin
            if (span == 0 || (style == 8 && k > 0))
            begin
                x = wide_coord();
                y = wide_coord();
            end
            else if (k > 0)
            begin
                x = x + int'($urandom_range(0, 2 * span)) - span;
                y = y + int'($urandom_range(0, 2 * span)) - span;
            end
            send_point(x, y, k == len - 1);
        end
    endtask

    task automatic random_phase(int target);
        int start, len;
        start = points_sent;
        while (points_sent - start < target)
        begin
            len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 6);
            random_list(len);
        end
    endtask

    initial
    begin
        logic [CFG_BITS-1:0] steps_plan[10] = '{7'd3, 7'd1, 7'd2, 7'd0, 7'd64,
                                                 7'd127, 7'd5, 7'd9, 7'd32, 7'd16};
        int                  phase_len[10]  = '{40, 30, 30, 25, 12, 10, 40, 40, 20, 40};

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset N of 16
        send_point(0, 0, 1);                        // one-point list
        send_point(100, 200, 0);                    // two-point list
        send_point(-300, 50, 1);
        send_point(8388607, 8388607, 0);            // extreme corners
        send_point(-8388608, -8388608, 0);
        send_point(8388607, -8388608, 0);
        send_point(-8388608, 8388607, 1);
        send_point(10, 10, 0);                      // coincident points: only the first point emitted
        send_point(10, 10, 0);
        send_point(10, 10, 1);
        send_point(0, 0, 0);                        // end just on / just over one unit
        send_point(128, 0, 0);
        send_point(256, 0, 1);
        send_point(0, 0, 0);
        send_point(1, 256, 0);
        send_point(2, 257, 1);
        send_point(-1, -1, 0);                      // odd sums: midpoint rounding ties
        send_point(2000, 3001, 0);
        send_point(-3001, 1999, 0);
        send_point(5001, -4999, 1);
        send_point(7, 7, 0);
        send_point(7, 7, 1);                        // two equal points

        // hold off until every expected word is out
        drop_valid();
        while (pending != 0)
            @(negedge clk);

        calm = 1'b1;
        random_phase(15);
        calm = 1'b0;

        for (int p = 0; p < 10; p++)
        begin
            set_steps(steps_plan[p]);
            calm = (p == 6);
            random_phase(phase_len[p]);
            calm = 1'b0;
        end
        drop_valid();

        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        $display("sent %0d control points over %0d step settings, checked %0d curve words",
                 points_sent, settings_used, words_checked);
        if (fail_count == 0 && pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
